[rtl/array_binary_search_tree_assert.svh]
// Assertion macros for the array binary search tree checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH
`define ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH

// Same-cycle implication.
`define ABST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ABST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/abst_pkg.sv]
// Shared types and constants for the array binary search tree.
// No dependencies.
`timescale 1ns / 1ps

package abst_pkg;

	localparam int SLOTS_DEF   = 15;
	localparam int MAX_RESULTS = 15;
	localparam int KEY_W       = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_UNIQUE = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_EMPTY  = 3'd4,
		CMD_TRAV   = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 4'd0,
		ST_NO_ROOM   = 4'd1,
		ST_DUPLICATE = 4'd2,
		ST_FOUND     = 4'd3,
		ST_NOT_FOUND = 4'd4,
		ST_EMPTY     = 4'd5,
		ST_NOT_EMPTY = 4'd6,
		ST_ITEM      = 4'd7,
		ST_CLEARED   = 4'd8
	} status_t;

endpackage

[rtl/array_binary_search_tree.sv]
// Top level of the array binary search tree: command sequencer, used flags, key RAM.
// Depends on abst_pkg and abst_ram.
//
// channel  | dir | tdata           | tuser         | tlast
// s_       | in  | value (32, s)   | command (3)   | -
// m_       | out | result_value(s) | status (4)    | last
//
// Insert, unique insert and search check each used node on the path and compare its
// key, then check the free slot unless a unique insert or search matches a key, and
// respond. Clear and empty check respond directly. Traversal descends, reads, emits,
// steps to the next key and climbs for each stored key, then flushes the last one.
// s_tready is high only between commands; m_tready stalls hold the response and the traversal.
// Reset clears all used flags at once; the key RAM is not cleared.
`timescale 1ns / 1ps

module array_binary_search_tree import abst_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [KEY_W-1:0]    s_tdata,  // [31:0] value
	input  logic [CMD_W-1:0]    s_tuser,  // [2:0] command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [KEY_W-1:0]    m_tdata,  // [31:0] result_value
	output logic [STATUS_W-1:0] m_tuser,  // [3:0] status
	output logic                m_tlast
);

	localparam int AW = $clog2(SLOTS);
	localparam int PW = $clog2(2 * SLOTS + 1);
	localparam int CW = $clog2(MAX_RESULTS + 1);
	localparam logic [PW-1:0] SLOTS_P = PW'(SLOTS);
	localparam logic [CW-1:0] MAX_P   = CW'(MAX_RESULTS);

	typedef enum logic [3:0] {
		S_IDLE, S_RESP, S_WALK_CHK, S_WALK_CMP,
		S_TR_DESC, S_TR_READ, S_TR_EMIT, S_TR_SUCC, S_TR_UP, S_TR_FLUSH
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	status_t              st_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PW-1:0]        pos_q;
	logic [CW-1:0]        cnt_q;
	logic                 pend_q;
	logic [KEY_W-1:0]     pend_val_q;
	logic [SLOTS-1:0]     used_q;
	logic                 m_tvalid_q;
	logic [KEY_W-1:0]     m_tdata_q;
	status_t              m_tuser_q;
	logic                 m_tlast_q;

	logic signed [KEY_W-1:0] rdata;
	logic [PW-1:0]        child_base, left_pos, right_pos, parent_pos;
	logic                 pos_in, pos_used, left_used, right_used;
	logic                 key_eq, key_lt, out_free, ram_we, out_load;
	logic [AW-1:0]        ram_raddr;

	assign child_base = {pos_q[PW-2:0], 1'b0};
	assign left_pos   = child_base + PW'(1);
	assign right_pos  = child_base + PW'(2);
	assign parent_pos = (pos_q - PW'(1)) >> 1;

	assign pos_in     = pos_q < SLOTS_P;
	assign pos_used   = pos_in && used_q[pos_q[AW-1:0]];
	assign left_used  = (left_pos < SLOTS_P) && used_q[left_pos[AW-1:0]];
	assign right_used = (right_pos < SLOTS_P) && used_q[right_pos[AW-1:0]];

	assign key_eq   = key_q == rdata;
	assign key_lt   = key_q < rdata;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = out_free && ((state_q == S_RESP) || (state_q == S_TR_FLUSH) ||
		((state_q == S_TR_EMIT) && pend_q));

	assign ram_raddr = pos_in ? pos_q[AW-1:0] : '0;
	assign ram_we    = (state_q == S_WALK_CHK) && pos_in && !pos_used && (cmd_q != CMD_SEARCH);

	abst_ram #(
		.WIDTH(KEY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_raddr),
		.wdata(key_q),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= CMD_CLEAR;
			st_q       <= ST_CLEARED;
			key_q      <= '0;
			pos_q      <= '0;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pend_val_q <= '0;
			used_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ST_CLEARED;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						key_q  <= s_tdata;
						cmd_q  <= cmd_t'(s_tuser);
						pos_q  <= '0;
						cnt_q  <= '0;
						pend_q <= 1'b0;
						priority case (s_tuser)
							CMD_CLEAR: begin
								used_q  <= '0;
								st_q    <= ST_CLEARED;
								state_q <= S_RESP;
							end
							CMD_INSERT, CMD_UNIQUE, CMD_SEARCH: begin
								state_q <= S_WALK_CHK;
							end
							CMD_EMPTY: begin
								st_q    <= used_q[0] ? ST_NOT_EMPTY : ST_EMPTY;
								state_q <= S_RESP;
							end
							CMD_TRAV: begin
								st_q    <= ST_EMPTY;
								state_q <= used_q[0] ? S_TR_DESC : S_RESP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= '0;
						m_tuser_q  <= st_q;
						m_tlast_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_WALK_CHK: begin
					if (pos_used) begin
						state_q <= S_WALK_CMP;
					end else begin
						if (cmd_q == CMD_SEARCH) begin
							st_q <= ST_NOT_FOUND;
						end else if (!pos_in) begin
							st_q <= ST_NO_ROOM;
						end else begin
							used_q[pos_q[AW-1:0]] <= 1'b1;
							st_q <= ST_INSERTED;
						end
						state_q <= S_RESP;
					end
				end
				S_WALK_CMP: begin
					if (cmd_q != CMD_INSERT && key_eq) begin
						st_q    <= (cmd_q == CMD_SEARCH) ? ST_FOUND : ST_DUPLICATE;
						state_q <= S_RESP;
					end else begin
						pos_q   <= key_lt ? left_pos : right_pos;
						state_q <= S_WALK_CHK;
					end
				end
				S_TR_DESC: begin
					if (left_used) begin
						pos_q <= left_pos;
					end else begin
						state_q <= S_TR_READ;
					end
				end
				S_TR_READ: begin
					state_q <= S_TR_EMIT;
				end
				S_TR_EMIT: begin
					if (!pend_q || out_free) begin
						if (pend_q) begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= pend_val_q;
							m_tuser_q  <= ST_ITEM;
							m_tlast_q  <= 1'b0;
						end
						pend_q     <= 1'b1;
						pend_val_q <= rdata;
						cnt_q      <= cnt_q + CW'(1);
						state_q    <= (cnt_q + CW'(1) == MAX_P) ? S_TR_FLUSH : S_TR_SUCC;
					end
				end
				S_TR_SUCC: begin
					if (right_used) begin
						pos_q   <= right_pos;
						state_q <= S_TR_DESC;
					end else begin
						state_q <= S_TR_UP;
					end
				end
				S_TR_UP: begin
					if (pos_q == '0) begin
						state_q <= S_TR_FLUSH;
					end else if (!pos_q[0]) begin
						pos_q <= parent_pos;
					end else begin
						pos_q   <= parent_pos;
						state_q <= S_TR_READ;
					end
				end
				S_TR_FLUSH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= pend_val_q;
						m_tuser_q  <= ST_ITEM;
						m_tlast_q  <= 1'b1;
						pend_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/abst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module abst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 15
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/abst_chk.sv]
// Port-level checker for the array binary search tree, bound to the top level.
// Depends on abst_pkg and array_binary_search_tree_assert.svh.
`timescale 1ns / 1ps
`include "array_binary_search_tree_assert.svh"

module abst_chk import abst_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [CMD_W-1:0]    s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [KEY_W-1:0]    m_tdata,
	input logic [STATUS_W-1:0] m_tuser,
	input logic                m_tlast
);

	logic                      st_result;
	logic                      cmd_xfer;
	logic                      m_stall;
	logic [KEY_W+STATUS_W:0]   m_bus;

	assign st_result = m_tvalid && (m_tuser != ST_ITEM);
	assign cmd_xfer  = s_tvalid && s_tready && (s_tuser <= CMD_TRAV);
	assign m_stall   = m_tvalid && !m_tready;
	assign m_bus     = {m_tdata, m_tuser, m_tlast};

	`ABST_ASSERT_NOW(a_value_zero, st_result, m_tdata == '0, "nonzero value on a status result")
	`ABST_ASSERT_NOW(a_status_last, st_result, m_tlast, "status result without last")
	`ABST_ASSERT_NEXT(a_busy, cmd_xfer, !s_tready, "ready held after a command transfer")
	`ABST_ASSERT_NEXT(a_hold, m_stall, m_tvalid && $stable(m_bus), "stalled result changed")

endmodule

bind array_binary_search_tree abst_chk u_abst_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
